// ===== rtl/sjf_pkg.sv =====
`default_nettype none

package sjf_pkg;

    localparam int DATA_W = 16;
    localparam int TIME_W = 22;
    localparam int SUM_W  = 27;
    localparam int ID_W   = 6;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN_INIT,
        ST_SCAN,
        ST_COMMIT,
        ST_OUT_READ,
        ST_OUT_CALC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_wr;
        logic scan_init;
        logic commit;
        logic out_init;
        logic out_read;
        logic out_load;
        logic out_adv;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic sched_last;
        logic out_last;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/sjf_ctrl.sv =====
`default_nettype none

module sjf_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            last_job,
    input  wire logic            out_ready,
    input  wire sjf_pkg::status_t status,
    output sjf_pkg::cmd_t        cmd,
    output logic                 in_ready,
    output logic                 out_valid
);

    sjf_pkg::state_t state_reg;
    sjf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sjf_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            sjf_pkg::ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_wr = 1'b1;
                    if (last_job)
                    begin
                        state_next = sjf_pkg::ST_SCAN_INIT;
                    end
                end
            end
            sjf_pkg::ST_SCAN_INIT:
            begin
                cmd.scan_init = 1'b1;
                state_next    = sjf_pkg::ST_SCAN;
            end
            sjf_pkg::ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = sjf_pkg::ST_COMMIT;
                end
            end
            sjf_pkg::ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                if (status.sched_last)
                begin
                    cmd.out_init = 1'b1;
                    state_next   = sjf_pkg::ST_OUT_READ;
                end
                else
                begin
                    state_next = sjf_pkg::ST_SCAN_INIT;
                end
            end
            sjf_pkg::ST_OUT_READ:
            begin
                cmd.out_read = 1'b1;
                state_next   = sjf_pkg::ST_OUT_CALC;
            end
            sjf_pkg::ST_OUT_CALC:
            begin
                cmd.out_load = 1'b1;
                state_next   = sjf_pkg::ST_OUT;
            end
            sjf_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.out_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = sjf_pkg::ST_LOAD;
                    end
                    else
                    begin
                        cmd.out_adv = 1'b1;
                        state_next  = sjf_pkg::ST_OUT_READ;
                    end
                end
            end
            default:
            begin
                state_next = sjf_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/sjf_datapath.sv =====
`default_nettype none

module sjf_datapath #(
    parameter int MAX_PROCS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sjf_pkg::cmd_t                 cmd,
    output sjf_pkg::status_t                   status,
    input  wire logic [sjf_pkg::DATA_W-1:0]    arrival_time,
    input  wire logic [sjf_pkg::DATA_W-1:0]    burst_time,
    output logic      [sjf_pkg::ID_W-1:0]      job_id,
    output logic      [sjf_pkg::TIME_W-1:0]    completion_time,
    output logic      [sjf_pkg::TIME_W-1:0]    turnaround_time,
    output logic      [sjf_pkg::TIME_W-1:0]    waiting_time,
    output logic      [sjf_pkg::TIME_W-1:0]    response_time,
    output logic      [sjf_pkg::SUM_W-1:0]     sum_completion,
    output logic      [sjf_pkg::SUM_W-1:0]     sum_turnaround,
    output logic      [sjf_pkg::SUM_W-1:0]     sum_waiting,
    output logic      [sjf_pkg::SUM_W-1:0]     sum_response,
    output logic                               final_result
);

    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam int DW = sjf_pkg::DATA_W;
    localparam int TW = sjf_pkg::TIME_W;
    localparam int SW = sjf_pkg::SUM_W;

    logic [DW-1:0] arrival_mem    [MAX_PROCS];
    logic [DW-1:0] burst_mem      [MAX_PROCS];
    logic [TW-1:0] completion_mem [MAX_PROCS];

    logic [CW-1:0]        job_count_reg;
    logic [CW-1:0]        fin_cnt_reg;
    logic [TW-1:0]        clock_reg;
    logic [MAX_PROCS-1:0] done_reg;

    logic [IW-1:0] scan_idx_reg;
    logic          issue_reg;
    logic          pipe_vld_reg;
    logic [IW-1:0] pipe_idx_reg;
    logic [DW-1:0] arr_rd_reg;
    logic [DW-1:0] burst_rd_reg;
    logic [TW-1:0] comp_rd_reg;

    // Best job that has already arrived, and best job by earliest arrival.
    logic          a_vld_reg;
    logic [IW-1:0] a_idx_reg;
    logic [DW-1:0] a_arr_reg;
    logic [DW-1:0] a_burst_reg;
    logic          e_vld_reg;
    logic [IW-1:0] e_idx_reg;
    logic [DW-1:0] e_arr_reg;
    logic [DW-1:0] e_burst_reg;

    logic [IW-1:0] out_idx_reg;
    logic [SW-1:0] sc_reg;
    logic [SW-1:0] st_reg;
    logic [SW-1:0] sw_reg;

    logic [CW-1:0] count_m1;
    logic          full;
    logic [IW-1:0] rd_addr;
    logic          cand_ok;
    logic          arrived;
    logic          a_better;
    logic          e_better;
    logic [IW-1:0] pick_idx;
    logic [TW-1:0] start_time;
    logic [DW-1:0] pick_burst;
    logic [TW-1:0] clock_next;
    logic [TW-1:0] tat;
    logic [TW-1:0] wt;
    logic [SW-1:0] sc_next;
    logic [SW-1:0] st_next;
    logic [SW-1:0] sw_next;
    logic          is_last_out;

    assign count_m1 = job_count_reg - CW'(1);
    assign full     = (job_count_reg == CW'(MAX_PROCS));
    assign rd_addr  = cmd.out_read ? out_idx_reg : scan_idx_reg;

    assign cand_ok  = pipe_vld_reg && !done_reg[pipe_idx_reg];
    assign arrived  = (TW'(arr_rd_reg) <= clock_reg);
    assign a_better = !a_vld_reg || (burst_rd_reg < a_burst_reg) ||
                      ((burst_rd_reg == a_burst_reg) && (arr_rd_reg < a_arr_reg));
    assign e_better = !e_vld_reg || (arr_rd_reg < e_arr_reg) ||
                      ((arr_rd_reg == e_arr_reg) && (burst_rd_reg < e_burst_reg));

    // With nothing arrived, the clock jumps to the earliest arrival first.
    assign pick_idx   = a_vld_reg ? a_idx_reg : e_idx_reg;
    assign start_time = a_vld_reg ? clock_reg : TW'(e_arr_reg);
    assign pick_burst = a_vld_reg ? a_burst_reg : e_burst_reg;
    assign clock_next = start_time + TW'(pick_burst);

    assign tat         = comp_rd_reg - TW'(arr_rd_reg);
    assign wt          = tat - TW'(burst_rd_reg);
    assign sc_next     = sc_reg + SW'(comp_rd_reg);
    assign st_next     = st_reg + SW'(tat);
    assign sw_next     = sw_reg + SW'(wt);
    assign is_last_out = (CW'(out_idx_reg) == count_m1);

    assign status.scan_done  = !issue_reg && !pipe_vld_reg;
    assign status.sched_last = (fin_cnt_reg == count_m1);
    assign status.out_last   = is_last_out;

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && !full)
        begin
            arrival_mem[job_count_reg[IW-1:0]] <= arrival_time;
            burst_mem[job_count_reg[IW-1:0]]   <= burst_time;
        end
        if (cmd.commit)
        begin
            completion_mem[pick_idx] <= clock_next;
        end
        arr_rd_reg   <= arrival_mem[rd_addr];
        burst_rd_reg <= burst_mem[rd_addr];
        comp_rd_reg  <= completion_mem[out_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_count_reg <= '0;
            fin_cnt_reg   <= '0;
            clock_reg     <= '0;
            done_reg      <= '0;
            scan_idx_reg  <= '0;
            issue_reg     <= 1'b0;
            pipe_vld_reg  <= 1'b0;
            a_vld_reg     <= 1'b0;
            e_vld_reg     <= 1'b0;
            out_idx_reg   <= '0;
        end
        else
        begin
            pipe_vld_reg <= issue_reg;
            if (cmd.load_wr && !full)
            begin
                job_count_reg <= job_count_reg + CW'(1);
            end
            if (cmd.scan_init)
            begin
                scan_idx_reg <= '0;
                issue_reg    <= 1'b1;
                a_vld_reg    <= 1'b0;
                e_vld_reg    <= 1'b0;
            end
            else
            begin
                if (issue_reg)
                begin
                    scan_idx_reg <= scan_idx_reg + IW'(1);
                    if (CW'(scan_idx_reg) == count_m1)
                    begin
                        issue_reg <= 1'b0;
                    end
                end
                if (cand_ok && arrived && a_better)
                begin
                    a_vld_reg <= 1'b1;
                end
                if (cand_ok && e_better)
                begin
                    e_vld_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                clock_reg          <= clock_next;
                done_reg[pick_idx] <= 1'b1;
                fin_cnt_reg        <= fin_cnt_reg + CW'(1);
            end
            if (cmd.out_init)
            begin
                out_idx_reg <= '0;
            end
            else if (cmd.out_adv)
            begin
                out_idx_reg <= out_idx_reg + IW'(1);
            end
            if (cmd.clear)
            begin
                job_count_reg <= '0;
                fin_cnt_reg   <= '0;
                clock_reg     <= '0;
                done_reg      <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_idx_reg <= scan_idx_reg;
        if (cand_ok && arrived && a_better)
        begin
            a_idx_reg   <= pipe_idx_reg;
            a_arr_reg   <= arr_rd_reg;
            a_burst_reg <= burst_rd_reg;
        end
        if (cand_ok && e_better)
        begin
            e_idx_reg   <= pipe_idx_reg;
            e_arr_reg   <= arr_rd_reg;
            e_burst_reg <= burst_rd_reg;
        end
        if (cmd.out_init)
        begin
            sc_reg <= '0;
            st_reg <= '0;
            sw_reg <= '0;
        end
        else if (cmd.out_load)
        begin
            sc_reg          <= sc_next;
            st_reg          <= st_next;
            sw_reg          <= sw_next;
            job_id          <= sjf_pkg::ID_W'(CW'(out_idx_reg) + CW'(1));
            completion_time <= comp_rd_reg;
            turnaround_time <= tat;
            waiting_time    <= wt;
            response_time   <= wt;
            sum_completion  <= is_last_out ? sc_next : '0;
            sum_turnaround  <= is_last_out ? st_next : '0;
            sum_waiting     <= is_last_out ? sw_next : '0;
            sum_response    <= is_last_out ? sw_next : '0;
            final_result    <= is_last_out;
        end
    end

    a_commit_has_cand: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (a_vld_reg || e_vld_reg))
        else $error("schedule commit without a candidate job");

    a_commit_undone: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !done_reg[pick_idx])
        else $error("schedule commit picked a finished job");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        job_count_reg <= CW'(MAX_PROCS))
        else $error("job count beyond store depth");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (job_count_reg == '0) && (done_reg == '0))
        else $error("job set not emptied after last result");

endmodule

`default_nettype wire

// ===== rtl/sjf_nonpreemptive_scheduler_unit.sv =====
// Loading: one job per cycle while the block is in its load phase.
// Scheduling: each job pick scans every stored entry (at most MAX_PROCS), one stored
// entry per cycle through the single read port of the job memories.
// Results: each beat passes ST_OUT_READ and ST_OUT_CALC, then waits in ST_OUT for the sink; then load resumes.
// Reset (rst_n low, asynchronous) empties the job set and returns to loading.
`default_nettype none

module sjf_nonpreemptive_scheduler_unit #(
    parameter int MAX_PROCS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [sjf_pkg::DATA_W-1:0]    arrival_time,
    input  wire logic [sjf_pkg::DATA_W-1:0]    burst_time,
    input  wire logic                          last_job,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [sjf_pkg::ID_W-1:0]      job_id,
    output logic      [sjf_pkg::TIME_W-1:0]    completion_time,
    output logic      [sjf_pkg::TIME_W-1:0]    turnaround_time,
    output logic      [sjf_pkg::TIME_W-1:0]    waiting_time,
    output logic      [sjf_pkg::TIME_W-1:0]    response_time,
    output logic      [sjf_pkg::SUM_W-1:0]     sum_completion,
    output logic      [sjf_pkg::SUM_W-1:0]     sum_turnaround,
    output logic      [sjf_pkg::SUM_W-1:0]     sum_waiting,
    output logic      [sjf_pkg::SUM_W-1:0]     sum_response,
    output logic                               final_result
);

    sjf_pkg::cmd_t    cmd;
    sjf_pkg::status_t status;

    sjf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_job  (last_job),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid)
    );

    sjf_datapath #(
        .MAX_PROCS (MAX_PROCS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .arrival_time    (arrival_time),
        .burst_time      (burst_time),
        .job_id          (job_id),
        .completion_time (completion_time),
        .turnaround_time (turnaround_time),
        .waiting_time    (waiting_time),
        .response_time   (response_time),
        .sum_completion  (sum_completion),
        .sum_turnaround  (sum_turnaround),
        .sum_waiting     (sum_waiting),
        .sum_response    (sum_response),
        .final_result    (final_result)
    );

endmodule

`default_nettype wire
